>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the layout RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layout assertion failed (same cycle)");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layout assertion failed (next cycle)");

`endif

>>> hw/rtl/sml_pkg.sv
// Shared types, codes and helpers for the struct member layout block.
`default_nettype none
package sml_pkg;

  localparam int SIZE_W  = 32;
  localparam int ALIGN_W = 13;
  localparam int BITW_W  = 7;
  localparam int FREE_W  = 3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_AFTER_FLEX   = 4'd1,
    ERR_INCOMPLETE   = 4'd2,
    ERR_FUNCTION     = 4'd3,
    ERR_HAS_FLEX     = 4'd4,
    ERR_BAD_ALIGN    = 4'd5,
    ERR_WEAK_ALIGN   = 4'd6,
    ERR_BF_TYPE      = 4'd7,
    ERR_BF_ALIGNAS   = 4'd8,
    ERR_BF_ZERO_NAME = 4'd9,
    ERR_BF_WIDE      = 4'd10,
    ERR_OVERFLOW     = 4'd11
  } err_t;

  typedef struct packed {
    logic                op;
    logic [SIZE_W-1:0]   member_size;
    logic [ALIGN_W-1:0]  member_align;
    logic [ALIGN_W-1:0]  explicit_align;
    logic                is_bitfield;
    logic [BITW_W-1:0]   bit_width;
    logic                has_name;
    logic                is_incomplete;
    logic                is_array;
    logic                is_function;
    logic                has_flexible;
    logic                is_integer;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   running_size;
    logic [ALIGN_W-1:0]  running_align;
    logic [FREE_W-1:0]   free_bits;
    logic                flexible_seen;
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   member_offset;
    logic [BITW_W-1:0]   bits_before;
    logic [BITW_W-1:0]   bits_after;
    logic                member_recorded;
    err_t                error_code;
    logic [SIZE_W-1:0]   total_size;
    logic [ALIGN_W-1:0]  total_align;
  } result_t;

  function automatic logic is_pow2(input logic [SIZE_W-1:0] v);
    return (v != '0) && ((v & (v - 1'b1)) == '0);
  endfunction

  function automatic logic [SIZE_W-1:0] ext_align(input logic [ALIGN_W-1:0] a);
    return {{(SIZE_W-ALIGN_W){1'b0}}, a};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sml_layout.sv
// Combinational layout step: checks one item and computes next state and result.
`default_nettype none
module sml_layout (
  input  sml_pkg::item_t   item,
  input  sml_pkg::state_t  cur,
  input  logic             is_union,
  output sml_pkg::state_t  nxt,
  output sml_pkg::result_t res
);

  localparam int SW = sml_pkg::SIZE_W;
  localparam int WW = sml_pkg::BITW_W;

  logic                        rec;
  logic                        align_bad;
  logic [SW-1:0]               msize;
  logic [SW-1:0]               cur_size;
  logic [SW-1:0]               union_max;

  // close rounding
  logic [SW-1:0]               ra_m1;
  logic [SW:0]                 close_sum;
  logic                        close_ovf;
  logic [SW-1:0]               close_fin;

  // plain member
  logic                        weak_align;
  logic [sml_pkg::ALIGN_W-1:0] eff_align;
  logic [SW-1:0]               pa_m1;
  logic [SW:0]                 pa_sum;
  logic [SW-1:0]               pa_off;
  logic [SW:0]                 pa_end;
  logic                        pa_ovf;

  // bit-field member
  logic                        bf_type_bad;
  logic                        bf_wide;
  logic [SW-1:0]               ms_m1;
  logic [SW:0]                 bf_sum;
  logic [SW-1:0]               bf_end;
  logic [SW-1:0]               bf_gap;
  logic [SW+2:0]               bf_room;
  logic                        bf_new_unit;
  logic [SW-1:0]               bf_sz1;
  logic [sml_pkg::FREE_W-1:0]  bf_bits1;
  logic [SW-1:0]               bf_base;
  logic [SW-1:0]               bf_off;
  logic [SW-1:0]               bf_span;
  logic [WW-1:0]               bf_before;
  logic [WW-1:0]               bf_after;
  logic [WW-1:0]               bu_after;
  logic [WW:0]                 bf_grow8;
  logic [SW:0]                 bf_grow_sum;
  logic [sml_pkg::FREE_W-1:0]  bf_bits2;

  assign rec       = item.has_name | ~item.is_bitfield;
  assign msize     = item.member_size;
  assign cur_size  = cur.running_size;
  assign union_max = (cur_size < msize) ? msize : cur_size;
  assign align_bad = ~sml_pkg::is_pow2(sml_pkg::ext_align(item.member_align)) |
                     ((item.explicit_align != '0) &&
                      ~sml_pkg::is_pow2(sml_pkg::ext_align(item.explicit_align)));

  assign ra_m1     = sml_pkg::ext_align(cur.running_align) - 1'b1;
  assign close_sum = {1'b0, cur_size} + {1'b0, ra_m1};
  assign close_ovf = (cur.running_align != '0) && close_sum[SW];
  assign close_fin = (cur.running_align == '0) ? cur_size : (close_sum[SW-1:0] & ~ra_m1);

  assign weak_align = (item.explicit_align != '0) &&
                      (item.explicit_align < item.member_align);
  assign eff_align  = item.is_bitfield ? item.member_align :
                      ((item.explicit_align < item.member_align) ?
                       item.member_align : item.explicit_align);
  assign pa_m1  = sml_pkg::ext_align(eff_align) - 1'b1;
  assign pa_sum = {1'b0, cur_size} + {1'b0, pa_m1};
  assign pa_off = pa_sum[SW-1:0] & ~pa_m1;
  assign pa_end = {1'b0, pa_off} + {1'b0, msize};
  assign pa_ovf = pa_sum[SW] | pa_end[SW];

  assign bf_type_bad = ~item.is_integer | ~sml_pkg::is_pow2(msize);
  assign bf_wide     = {{(SW+3-WW){1'b0}}, item.bit_width} > {msize, 3'b000};
  assign ms_m1       = msize - 1'b1;
  assign bf_sum      = {1'b0, cur_size} + {1'b0, ms_m1};
  assign bf_end      = bf_sum[SW-1:0] & ~ms_m1;
  // distance to the next unit boundary, formed beside the rounding add
  assign bf_gap      = (~cur_size + 1'b1) & ms_m1;
  assign bf_room     = {bf_gap, 3'b000} + {{SW{1'b0}}, cur.free_bits};
  assign bf_new_unit = (item.bit_width == '0) ||
                       ({{(SW+3-WW){1'b0}}, item.bit_width} > bf_room);
  assign bf_sz1      = bf_new_unit ? bf_end : cur_size;
  assign bf_bits1    = bf_new_unit ? '0 : cur.free_bits;
  // a fresh unit starts at its own boundary; otherwise back up into a partly used byte
  assign bf_base     = ((cur.free_bits != '0) && (cur_size != '0)) ? (cur_size - 1'b1) :
                       cur_size;
  assign bf_off      = bf_new_unit ? bf_end : (bf_base & ~ms_m1);
  assign bf_span     = bf_sz1 - bf_off;
  // counts wrap at seven bits
  assign bf_before   = {bf_span[3:0], 3'b000} - {{(WW-3){1'b0}}, bf_bits1};
  assign bf_after    = {msize[3:0], 3'b000} - item.bit_width - bf_before;
  assign bu_after    = {msize[3:0], 3'b000} - item.bit_width;
  assign bf_grow8    = ({1'b0, item.bit_width} + (WW+1)'(7)
                       - {{(WW+1-3){1'b0}}, bf_bits1}) >> 3;
  assign bf_grow_sum = {1'b0, bf_sz1} + {{(SW+1-(WW+1)){1'b0}}, bf_grow8};
  assign bf_bits2    = bf_bits1 - item.bit_width[2:0];

  always_comb begin
    logic                         ok;
    sml_pkg::err_t                err;
    logic [SW-1:0]                new_size;
    logic [sml_pkg::FREE_W-1:0]   new_bits;
    logic [SW-1:0]                off;
    logic [WW-1:0]                lead;
    logic [WW-1:0]                after;

    err      = sml_pkg::ERR_NONE;
    new_size = cur_size;
    new_bits = cur.free_bits;
    off      = '0;
    lead     = '0;
    after    = '0;

    if (item.op == sml_pkg::OP_CLOSE) begin
      if (close_ovf) err = sml_pkg::ERR_OVERFLOW;
    end else if (cur.flexible_seen) begin
      err = sml_pkg::ERR_AFTER_FLEX;
    end else if (item.is_incomplete && !item.is_array) begin
      err = sml_pkg::ERR_INCOMPLETE;
    end else if (item.is_function) begin
      err = sml_pkg::ERR_FUNCTION;
    end else if (item.has_flexible) begin
      err = sml_pkg::ERR_HAS_FLEX;
    end else if (align_bad) begin
      err = sml_pkg::ERR_BAD_ALIGN;
    end else if (!item.is_bitfield) begin
      new_bits = '0;
      if (weak_align) begin
        err = sml_pkg::ERR_WEAK_ALIGN;
      end else if (!is_union) begin
        if (pa_ovf) begin
          err = sml_pkg::ERR_OVERFLOW;
        end else begin
          new_size = pa_end[SW-1:0];
          off      = pa_off;
        end
      end else begin
        new_size = union_max;
      end
    end else if (bf_type_bad) begin
      err = sml_pkg::ERR_BF_TYPE;
    end else if (item.explicit_align != '0) begin
      err = sml_pkg::ERR_BF_ALIGNAS;
    end else if ((item.bit_width == '0) && item.has_name) begin
      err = sml_pkg::ERR_BF_ZERO_NAME;
    end else if (bf_wide) begin
      err = sml_pkg::ERR_BF_WIDE;
    end else if (!is_union) begin
      if (bf_sum[SW] || bf_grow_sum[SW]) begin
        err = sml_pkg::ERR_OVERFLOW;
      end else begin
        new_size = bf_grow_sum[SW-1:0];
        new_bits = bf_bits2;
        if (rec) begin
          off   = bf_off;
          lead  = bf_before;
          after = bf_after;
        end
      end
    end else if (rec) begin
      new_size = union_max;
      after    = bu_after;
    end

    ok = (err == sml_pkg::ERR_NONE);

    nxt = cur;
    res = '0;
    res.error_code  = err;
    res.total_size  = cur_size;
    res.total_align = cur.running_align;

    if (item.op == sml_pkg::OP_CLOSE) begin
      if (ok) begin
        nxt            = '0;
        res.total_size = close_fin;
      end
    end else if (ok) begin
      nxt.running_size = new_size;
      nxt.free_bits    = new_bits;
      if (item.is_incomplete) nxt.flexible_seen = 1'b1;
      if (rec && (cur.running_align < eff_align)) nxt.running_align = eff_align;
      res.member_offset   = off;
      res.bits_before     = lead;
      res.bits_after      = after;
      res.member_recorded = rec;
      res.total_size      = nxt.running_size;
      res.total_align     = nxt.running_align;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/struct_member_layout_top.sv
// Top level of the struct member layout block: input register, layout step, result register.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------------------
//  in       | sink      | in_valid / in_stall       | op, member_size ... is_integer
//  out      | source    | out_valid / out_stall     | member_offset ... total_align
//  cfg      | sink      | cfg_wr_en                 | cfg_wr_data (is_union)
//
// One item per cycle while out_stall is low; each item passes the input register, then
// the result register. The whole layout update (align, place, grow) is combinational from
// the input register against the running state, so the state loop sets the rate.
// Reset (rst, synchronous) empties both registers and clears state and is_union.
// A stalled result holds in the output register; the input register keeps taking
// transfers until it is full behind that stalled result, then in_stall rises.
`default_nettype none
`include "assert_macros.svh"
module struct_member_layout_top (
  input  wire logic                            clk,
  input  wire logic                            rst,

  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_wr_data,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            op,
  input  wire logic [sml_pkg::SIZE_W-1:0]      member_size,
  input  wire logic [sml_pkg::ALIGN_W-1:0]     member_align,
  input  wire logic [sml_pkg::ALIGN_W-1:0]     explicit_align,
  input  wire logic                            is_bitfield,
  input  wire logic [sml_pkg::BITW_W-1:0]      bit_width,
  input  wire logic                            has_name,
  input  wire logic                            is_incomplete,
  input  wire logic                            is_array,
  input  wire logic                            is_function,
  input  wire logic                            has_flexible,
  input  wire logic                            is_integer,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [sml_pkg::SIZE_W-1:0]           member_offset,
  output logic [sml_pkg::BITW_W-1:0]           bits_before,
  output logic [sml_pkg::BITW_W-1:0]           bits_after,
  output logic                                 member_recorded,
  output logic [3:0]                           error_code,
  output logic [sml_pkg::SIZE_W-1:0]           total_size,
  output logic [sml_pkg::ALIGN_W-1:0]          total_align
);

  // layout mode register
  logic             is_union;

  // running layout state
  sml_pkg::state_t  state;
  sml_pkg::state_t  state_next;

  // input register
  logic             s1_valid;
  sml_pkg::item_t   s1_item;
  sml_pkg::item_t   in_item;

  // result register
  sml_pkg::result_t out_res;
  sml_pkg::result_t step_res;

  logic             out_free;
  logic             s1_fire;
  logic             in_fire;

  // step outcome seen by the checks below
  logic             step_err;
  logic             step_close_ok;

  // Pack the input ports into one item.
  always_comb begin
    in_item.op             = op;
    in_item.member_size    = member_size;
    in_item.member_align   = member_align;
    in_item.explicit_align = explicit_align;
    in_item.is_bitfield    = is_bitfield;
    in_item.bit_width      = bit_width;
    in_item.has_name       = has_name;
    in_item.is_incomplete  = is_incomplete;
    in_item.is_array       = is_array;
    in_item.is_function    = is_function;
    in_item.has_flexible   = has_flexible;
    in_item.is_integer     = is_integer;
  end

  // The output register can take a new result when empty or when its result leaves now.
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  // Stall the input only while the input register is full behind a stalled result.
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  sml_layout u_layout (
    .item     (s1_item),
    .cur      (state),
    .is_union (is_union),
    .nxt      (state_next),
    .res      (step_res)
  );

  // Config write: taken whenever enabled; the user must issue it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_union <= 1'b0;
    end else if (cfg_wr_en) begin
      is_union <= cfg_wr_data;
    end
  end

  // Input register: load on a transfer, drain when the item moves to the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item <= in_item;
  end

  // Advance the running state as each item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Result register: fill from the layout step, drop after the transfer out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_res <= step_res;
  end

  assign member_offset   = out_res.member_offset;
  assign bits_before     = out_res.bits_before;
  assign bits_after      = out_res.bits_after;
  assign member_recorded = out_res.member_recorded;
  assign error_code      = out_res.error_code;
  assign total_size      = out_res.total_size;
  assign total_align     = out_res.total_align;

  assign step_err      = s1_fire && (step_res.error_code != sml_pkg::ERR_NONE);
  assign step_close_ok = s1_fire && (s1_item.op == sml_pkg::OP_CLOSE) &&
                         (step_res.error_code == sml_pkg::ERR_NONE);

  // A rejected item leaves the layout state untouched.
  `ASSERT_NEXT(a_err_keeps_state, clk, rst, step_err, $stable(state))
  // A clean close clears the layout state.
  `ASSERT_NEXT(a_close_clears, clk, rst, step_close_ok, state == '0)
  // The greatest alignment is zero or a single power of two.
  `ASSERT_NOW(a_align_pow2, clk, rst, 1'b1, $onehot0(state.running_align))
  // The input stalls only behind a full input register and a stalled result.
  `ASSERT_NOW(a_stall_cause, clk, rst, in_stall, s1_valid && out_valid && out_stall)

endmodule
`default_nettype wire
